[hw/rtl/scc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the swept circle collision check.
// Depends on nothing; scc_mul, scc_search_stage, the top level and the bench import it.
package scc_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int TICK_WIDTH      = 31;
    localparam int MUL_DIGIT       = 16;

    typedef enum logic [2:0] {
        OUT_HIT    = 3'd0,
        OUT_NEVER  = 3'd1,
        OUT_PAST   = 3'd2,
        OUT_BEYOND = 3'd3,
        OUT_STILL  = 3'd4
    } outcome_t;

    // Control word that travels with an item through the root search.
    typedef struct packed {
        logic     valid;
        outcome_t outcome;
    } ctl_t;

endpackage

[hw/rtl/scc_mul.sv]
`timescale 1ns / 1ps
// Pipelined signed multiplier, one 16-bit digit of the second operand per stage.
// Depends on scc_pkg for the digit size.
module scc_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    import scc_pkg::*;

    localparam int DIG  = MUL_DIGIT;
    localparam int NDIG = (BW + DIG - 1) / DIG;
    localparam int BPAD = NDIG * DIG;
    localparam int PW   = AW + BW;

    logic                   sign_reg [0:NDIG];
    logic [AW-1:0]          ma_reg   [0:NDIG-1];
    logic [BPAD-1:0]        mb_reg   [0:NDIG-1];
    logic [PW-1:0]          acc_reg  [0:NDIG];
    logic signed [PW-1:0]   p_reg;

    // Stage 0 splits the operands into sign and magnitude.
    always_ff @(posedge aclk) begin
        if (en) begin
            sign_reg[0] <= a[AW-1] ^ b[BW-1];
            ma_reg[0]   <= unsigned'(a[AW-1] ? -a : a);
            mb_reg[0]   <= BPAD'(unsigned'(b[BW-1] ? -b : b));
            acc_reg[0]  <= '0;
        end
    end

    for (genvar i = 1; i <= NDIG; i++) begin : g_digit
        logic [AW+DIG-1:0] pp;
        assign pp = (AW+DIG)'(ma_reg[i-1]) * (AW+DIG)'(mb_reg[i-1][DIG*(i-1) +: DIG]);

        always_ff @(posedge aclk) begin
            if (en) begin
                sign_reg[i] <= sign_reg[i-1];
                acc_reg[i]  <= acc_reg[i-1] + (PW'(pp) << (DIG * (i - 1)));
            end
        end

        if (i < NDIG) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    ma_reg[i] <= ma_reg[i-1];
                    mb_reg[i] <= mb_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sign_reg[NDIG] ? -signed'(acc_reg[NDIG]) : signed'(acc_reg[NDIG]);
        end
    end

    assign p = p_reg;

endmodule

[hw/rtl/scc_delay.sv]
`timescale 1ns / 1ps
// Stallable delay line with a valid bit, used to keep item data aligned with
// the multipliers. Depends on nothing.
module scc_delay #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    output logic [DW-1:0] out_data
);
    logic          v_reg [0:DEPTH-1];
    logic [DW-1:0] d_reg [0:DEPTH-1];

    for (genvar i = 0; i < DEPTH; i++) begin : g_tap
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[i] <= (i == 0) ? in_data : d_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_data  = d_reg[DEPTH-1];

endmodule

[hw/rtl/scc_search_stage.sv]
`timescale 1ns / 1ps
// One bit of the contact time search: tries to set bit BIT of the time and
// updates the scaled quadratic and its slope by shifts and adds. Uses scc_pkg.
module scc_search_stage #(
    parameter int BIT = 0,
    parameter int AW  = 66,
    parameter int LW  = 98,
    parameter int FW  = 132,
    parameter int SW  = 128
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic [scc_pkg::TICK_WIDTH-1:0]   tick,
    input  scc_pkg::ctl_t                    ctl_in,
    input  logic [scc_pkg::TICK_WIDTH-1:0]   k_in,
    input  logic signed [LW-1:0]             lin_in,
    input  logic signed [FW-1:0]             f_in,
    input  logic [AW-1:0]                    a_in,
    input  logic [SW-1:0]                    side_in,
    output scc_pkg::ctl_t                    ctl_out,
    output logic [scc_pkg::TICK_WIDTH-1:0]   k_out,
    output logic signed [LW-1:0]             lin_out,
    output logic signed [FW-1:0]             f_out,
    output logic [AW-1:0]                    a_out,
    output logic [SW-1:0]                    side_out
);
    import scc_pkg::*;

    logic [TICK_WIDTH-1:0] cand;
    logic signed [LW-1:0]  lin_c;
    logic signed [FW-1:0]  f_c;
    logic                  take;

    logic                  valid_reg;
    outcome_t              outcome_reg;
    logic [TICK_WIDTH-1:0] k_reg;
    logic signed [LW-1:0]  lin_reg;
    logic signed [FW-1:0]  f_reg;
    logic [AW-1:0]         a_reg;
    logic [SW-1:0]         side_reg;

    // f(k + d) = f(k) + 2 d lin(k) + a d^2 and lin(k + d) = lin(k) + a d.
    assign cand  = k_in | (TICK_WIDTH'(1) << BIT);
    assign lin_c = lin_in + signed'(LW'(a_in) << BIT);
    assign f_c   = f_in + (FW'(lin_in) <<< (BIT + 1)) + signed'(FW'(a_in) << (2 * BIT));
    assign take  = (cand <= tick) && (lin_c[LW-1] || (lin_c == '0)) && !f_c[FW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            outcome_reg <= ctl_in.outcome;
            k_reg       <= take ? cand  : k_in;
            lin_reg     <= take ? lin_c : lin_in;
            f_reg       <= take ? f_c   : f_in;
            a_reg       <= a_in;
            side_reg    <= side_in;
        end
    end

    assign ctl_out  = '{valid: valid_reg, outcome: outcome_reg};
    assign k_out    = k_reg;
    assign lin_out  = lin_reg;
    assign f_out    = f_reg;
    assign a_out    = a_reg;
    assign side_out = side_reg;

endmodule

[hw/rtl/scc_skid.sv]
`timescale 1ns / 1ps
// Two-entry output buffer; its ready is registered and stalls the pipeline
// only when both entries hold items. Depends on nothing.
module scc_skid #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          ready,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [DW-1:0] m_data
);
    logic          main_v_reg, main_v_next;
    logic          spare_v_reg, spare_v_next;
    logic [DW-1:0] main_d_reg, main_d_next;
    logic [DW-1:0] spare_d_reg, spare_d_next;
    logic          pop;

    assign pop = main_v_reg && m_ready;

    always_comb begin
        main_v_next  = main_v_reg;
        spare_v_next = spare_v_reg;
        main_d_next  = main_d_reg;
        spare_d_next = spare_d_reg;
        if (!main_v_reg || pop) begin
            if (spare_v_reg) begin
                main_v_next  = 1'b1;
                main_d_next  = spare_d_reg;
                spare_v_next = 1'b0;
            end else begin
                main_v_next = push;
                main_d_next = push_data;
            end
        end else if (push) begin
            spare_v_next = 1'b1;
            spare_d_next = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg  <= 1'b0;
            spare_v_reg <= 1'b0;
        end else begin
            main_v_reg  <= main_v_next;
            spare_v_reg <= spare_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_d_reg  <= main_d_next;
        spare_d_reg <= spare_d_next;
    end

    assign ready   = !spare_v_reg;
    assign m_valid = main_v_reg;
    assign m_data  = main_d_reg;

endmodule

[hw/rtl/swept_circle_collision_check.sv]
`timescale 1ns / 1ps
// Swept circle collision check, top level. Uses scc_pkg, scc_mul, scc_delay,
// scc_search_stage and scc_skid.
//
// Each input item describes two circles moving at constant velocity; the block
// answers whether they first touch at a time between zero and tick_interval,
// and if so when (floor of the time in Q15.16) and where the second circle is
// then (floored, saturated). A new item is taken every cycle while the output
// buffer has room. An item passes through the pipelined multipliers (one
// 16-bit digit per stage) and the 31-stage contact time search, which fixes
// one time bit per stage. A two-entry output buffer lets input continue while
// one result waits; the input stalls only once both entries are full. The
// decisions are exact: the discriminant sign, the past-contact test and the
// search all work on full width integers, so no rounding happens before the
// outcome is chosen.
// tick_interval may be rewritten only while no item is in flight.
module swept_circle_collision_check #(
    parameter int COORD_WIDTH = scc_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = scc_pkg::DEF_FRAC_BITS,
    localparam int IN_BITS    = 10 * COORD_WIDTH - 2,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = scc_pkg::TICK_WIDTH + 2 * COORD_WIDTH,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: tick_interval, unsigned Q15.16.
    input  logic                            cfg_wr_en,
    input  logic [scc_pkg::TICK_WIDTH-1:0]  cfg_wr_data,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: first_pos_x, first_pos_y, first_vel_x, first_vel_y,
    // first_radius, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
    // second_radius, zero padding.
    input  logic [IN_W-1:0]                 s_tdata,
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0: contact_time, contact_x, contact_y, zero padding.
    output logic [OUT_W-1:0]                m_tdata,
    // From bit 0: hit, outcome.
    output logic [3:0]                      m_tuser
);
    import scc_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int TW     = TICK_WIDTH;
    localparam int DW1    = W + 1;
    localparam int PW1    = 2 * DW1;
    localparam int AW     = 2 * W + 2;
    localparam int CW     = 2 * W + 3;
    localparam int DSW    = 2 * CW;
    localparam int LW     = 2 * W + TW + 3;
    localparam int FW     = 2 * W + 2 * TW + 4;
    localparam int SIDE_W = 4 * W;
    localparam int XW     = W + TW + 1;
    localparam int SW     = W + TW + 2;
    localparam int RES_W  = 4 + TW + 2 * W;
    localparam int M1_LAT = (DW1 + MUL_DIGIT - 1) / MUL_DIGIT + 2;
    localparam int M2_LAT = (CW + MUL_DIGIT - 1) / MUL_DIGIT + 2;
    localparam int D2_W   = 1 + AW + AW + CW + SIDE_W;

    localparam logic signed [SW-1:0] C_MAX = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] C_MIN = -C_MAX - SW'(1);

    // Whole pipeline advances together; only a full output buffer stops it.
    logic en;

    // Configuration register.
    logic [TW-1:0] tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= TW'(1) << F;
        end else if (cfg_wr_en) begin
            tick_reg <= cfg_wr_data;
        end
    end

    // Input fields.
    logic signed [W-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    logic [W-2:0]        r1, r2;

    assign p1x = signed'(s_tdata[0 +: W]);
    assign p1y = signed'(s_tdata[W +: W]);
    assign v1x = signed'(s_tdata[2*W +: W]);
    assign v1y = signed'(s_tdata[3*W +: W]);
    assign r1  = s_tdata[4*W +: W-1];
    assign p2x = signed'(s_tdata[5*W-1 +: W]);
    assign p2y = signed'(s_tdata[6*W-1 +: W]);
    assign v2x = signed'(s_tdata[7*W-1 +: W]);
    assign v2y = signed'(s_tdata[8*W-1 +: W]);
    assign r2  = s_tdata[9*W-1 +: W-1];

    // Stage A: relative motion, radius sum and the no-motion test.
    logic                  a_valid_reg;
    logic signed [DW1-1:0] dvx_reg, dvy_reg, dpx_reg, dpy_reg;
    logic [W-1:0]          rs_reg;
    logic                  a_still_reg;
    logic [SIDE_W-1:0]     a_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvx_reg     <= DW1'(v1x) - DW1'(v2x);
            dvy_reg     <= DW1'(v1y) - DW1'(v2y);
            dpx_reg     <= DW1'(p1x) - DW1'(p2x);
            dpy_reg     <= DW1'(p1y) - DW1'(p2y);
            rs_reg      <= W'(r1) + W'(r2);
            a_still_reg <= (v1x == v2x) && (v1y == v2y);
            a_side_reg  <= {v2y, v2x, p2y, p2x};
        end
    end

    // First products: the terms of a = dv.dv, h = dp.dv and c.
    logic signed [DW1-1:0] rs_s;
    logic signed [PW1-1:0] sq_x, sq_y, hp_x, hp_y, pp_x, pp_y, rr;

    assign rs_s = signed'({1'b0, rs_reg});

    scc_mul #(.AW(DW1), .BW(DW1)) u_mul_sqx (
        .aclk(aclk), .en(en), .a(dvx_reg), .b(dvx_reg), .p(sq_x));
    scc_mul #(.AW(DW1), .BW(DW1)) u_mul_sqy (
        .aclk(aclk), .en(en), .a(dvy_reg), .b(dvy_reg), .p(sq_y));
    scc_mul #(.AW(DW1), .BW(DW1)) u_mul_hx (
        .aclk(aclk), .en(en), .a(dpx_reg), .b(dvx_reg), .p(hp_x));
    scc_mul #(.AW(DW1), .BW(DW1)) u_mul_hy (
        .aclk(aclk), .en(en), .a(dpy_reg), .b(dvy_reg), .p(hp_y));
    scc_mul #(.AW(DW1), .BW(DW1)) u_mul_px (
        .aclk(aclk), .en(en), .a(dpx_reg), .b(dpx_reg), .p(pp_x));
    scc_mul #(.AW(DW1), .BW(DW1)) u_mul_py (
        .aclk(aclk), .en(en), .a(dpy_reg), .b(dpy_reg), .p(pp_y));
    scc_mul #(.AW(DW1), .BW(DW1)) u_mul_rr (
        .aclk(aclk), .en(en), .a(rs_s), .b(rs_s), .p(rr));

    logic                d1_valid;
    logic [SIDE_W:0]     d1_data;

    scc_delay #(.DW(SIDE_W + 1), .DEPTH(M1_LAT)) u_dly_m1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(a_valid_reg), .in_data({a_still_reg, a_side_reg}),
        .out_valid(d1_valid), .out_data(d1_data));

    // Stage B: quadratic coefficients.
    logic                 b_valid_reg;
    logic [AW-1:0]        b_a_reg;
    logic signed [AW-1:0] b_h_reg;
    logic signed [CW-1:0] b_c_reg;
    logic                 b_still_reg;
    logic [SIDE_W-1:0]    b_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_a_reg     <= unsigned'(sq_x + sq_y);
            b_h_reg     <= hp_x + hp_y;
            b_c_reg     <= CW'(pp_x) + CW'(pp_y) - CW'(rr);
            b_still_reg <= d1_data[SIDE_W];
            b_side_reg  <= d1_data[SIDE_W-1:0];
        end
    end

    // Second products: h^2 and a*c for the discriminant.
    logic signed [CW-1:0]  h_ext, a_ext;
    logic signed [DSW-1:0] hh, ac;

    assign h_ext = CW'(b_h_reg);
    assign a_ext = signed'(CW'(b_a_reg));

    scc_mul #(.AW(CW), .BW(CW)) u_mul_hh (
        .aclk(aclk), .en(en), .a(h_ext), .b(h_ext), .p(hh));
    scc_mul #(.AW(CW), .BW(CW)) u_mul_ac (
        .aclk(aclk), .en(en), .a(a_ext), .b(b_c_reg), .p(ac));

    logic            d2_valid;
    logic [D2_W-1:0] d2_data;

    scc_delay #(.DW(D2_W), .DEPTH(M2_LAT)) u_dly_m2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(b_valid_reg),
        .in_data({b_still_reg, b_a_reg, b_h_reg, b_c_reg, b_side_reg}),
        .out_valid(d2_valid), .out_data(d2_data));

    logic                 d2_still;
    logic [AW-1:0]        d2_a;
    logic signed [AW-1:0] d2_h;
    logic signed [CW-1:0] d2_c;
    logic [SIDE_W-1:0]    d2_side;

    assign {d2_still, d2_a} = d2_data[D2_W-1 -: AW + 1];
    assign d2_h    = signed'(d2_data[SIDE_W + CW +: AW]);
    assign d2_c    = signed'(d2_data[SIDE_W +: CW]);
    assign d2_side = d2_data[SIDE_W-1:0];

    // Stage C: classify the item. Motion is checked first, then whether any
    // contact exists, then whether the first contact lies in the past.
    // Circles already overlapping at time zero count as past contact.
    logic signed [DSW-1:0] disc;
    outcome_t              c_outcome;

    assign disc = hh - ac;

    always_comb begin
        if (d2_still) begin
            c_outcome = OUT_STILL;
        end else if (disc[DSW-1]) begin
            c_outcome = OUT_NEVER;
        end else if (!((d2_h[AW-1] || (d2_h == '0)) && !d2_c[CW-1])) begin
            c_outcome = OUT_PAST;
        end else begin
            c_outcome = OUT_HIT;
        end
    end

    logic                 c_valid_reg;
    outcome_t             c_outcome_reg;
    logic signed [LW-1:0] c_lin_reg;
    logic signed [FW-1:0] c_f_reg;
    logic [AW-1:0]        c_a_reg;
    logic [SIDE_W-1:0]    c_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= d2_valid;
        end
    end

    // The search runs on the quadratic scaled to time steps of 2^-F:
    // f(k) = a k^2 + 2 h 2^F k + c 2^2F, with slope term lin(k) = a k + h 2^F.
    always_ff @(posedge aclk) begin
        if (en) begin
            c_outcome_reg <= c_outcome;
            c_lin_reg     <= LW'(d2_h) <<< F;
            c_f_reg       <= FW'(d2_c) <<< (2 * F);
            c_a_reg       <= d2_a;
            c_side_reg    <= d2_side;
        end
    end

    // Contact time search, most significant bit first. Each stage keeps the
    // time bit when the candidate time is still at or before the first root
    // and within the interval.
    ctl_t                 s_ctl  [0:TW];
    logic [TW-1:0]        s_k    [0:TW];
    logic signed [LW-1:0] s_lin  [0:TW];
    logic signed [FW-1:0] s_f    [0:TW];
    logic [AW-1:0]        s_a    [0:TW];
    logic [SIDE_W-1:0]    s_side [0:TW];

    assign s_ctl[0]  = '{valid: c_valid_reg, outcome: c_outcome_reg};
    assign s_k[0]    = '0;
    assign s_lin[0]  = c_lin_reg;
    assign s_f[0]    = c_f_reg;
    assign s_a[0]    = c_a_reg;
    assign s_side[0] = c_side_reg;

    for (genvar j = 0; j < TW; j++) begin : g_search
        scc_search_stage #(
            .BIT(TW - 1 - j), .AW(AW), .LW(LW), .FW(FW), .SW(SIDE_W)
        ) u_stage (
            .aclk(aclk), .aresetn(aresetn), .en(en), .tick(tick_reg),
            .ctl_in(s_ctl[j]), .k_in(s_k[j]), .lin_in(s_lin[j]), .f_in(s_f[j]),
            .a_in(s_a[j]), .side_in(s_side[j]),
            .ctl_out(s_ctl[j+1]), .k_out(s_k[j+1]), .lin_out(s_lin[j+1]),
            .f_out(s_f[j+1]), .a_out(s_a[j+1]), .side_out(s_side[j+1]));
    end

    // Stage X1: the search stops at the interval end; if the quadratic is
    // still positive and falling there, the first contact lies beyond it.
    // The position products are formed here as well.
    ctl_t                 e_ctl;
    logic [TW-1:0]        e_k;
    logic signed [LW-1:0] e_lin;
    logic signed [FW-1:0] e_f;
    logic [SIDE_W-1:0]    e_side;
    logic                 beyond;
    logic signed [XW-1:0] k_s;

    assign e_ctl  = s_ctl[TW];
    assign e_k    = s_k[TW];
    assign e_lin  = s_lin[TW];
    assign e_f    = s_f[TW];
    assign e_side = s_side[TW];
    assign beyond = (e_ctl.outcome == OUT_HIT) && (e_k == tick_reg) && e_lin[LW-1]
                    && !e_f[FW-1] && (e_f != '0);
    assign k_s    = signed'(XW'(e_k));

    logic                 x_valid_reg;
    outcome_t             x_outcome_reg;
    logic [TW-1:0]        x_k_reg;
    logic signed [W-1:0]  x_p2x_reg, x_p2y_reg;
    logic signed [XW-1:0] x_prodx_reg, x_prody_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
        end else if (en) begin
            x_valid_reg <= e_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_outcome_reg <= beyond ? OUT_BEYOND : e_ctl.outcome;
            x_k_reg       <= e_k;
            x_p2x_reg     <= signed'(e_side[0 +: W]);
            x_p2y_reg     <= signed'(e_side[W +: W]);
            x_prodx_reg   <= XW'(signed'(e_side[2*W +: W])) * k_s;
            x_prody_reg   <= XW'(signed'(e_side[3*W +: W])) * k_s;
        end
    end

    // Stage X2: floor(p2 + v2 * t) with saturation to the coordinate range.
    function automatic logic signed [W-1:0] contact_coord(
        input logic signed [W-1:0]  pos,
        input logic signed [XW-1:0] prod
    );
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] q;
        sum = (SW'(pos) <<< F) + SW'(prod);
        q   = sum >>> F;
        if (q > C_MAX) begin
            q = C_MAX;
        end else if (q < C_MIN) begin
            q = C_MIN;
        end
        return W'(q);
    endfunction

    logic                hit;
    logic [TW-1:0]       res_time;
    logic signed [W-1:0] res_x, res_y;
    logic [RES_W-1:0]    res_data;

    assign hit      = (x_outcome_reg == OUT_HIT);
    assign res_time = hit ? x_k_reg : '0;
    assign res_x    = hit ? contact_coord(x_p2x_reg, x_prodx_reg) : '0;
    assign res_y    = hit ? contact_coord(x_p2y_reg, x_prody_reg) : '0;
    assign res_data = {res_y, res_x, res_time, x_outcome_reg, hit};

    logic [RES_W-1:0] out_data;

    scc_skid #(.DW(RES_W)) u_skid (
        .aclk(aclk), .aresetn(aresetn),
        .push(en && x_valid_reg), .push_data(res_data), .ready(en),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(out_data));

    assign s_tready = en;
    assign m_tuser  = out_data[3:0];
    assign m_tdata  = OUT_W'(out_data[RES_W-1:4]);

endmodule

[bench/swept_circle_collision_check_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for swept_circle_collision_check: directed and random circle pairs
// under several tick intervals, with random stalls on both streams.
// Depends on scc_pkg and the swept_circle_collision_check RTL.
module swept_circle_collision_check_test;
    import scc_pkg::*;

    // Wide signed integer for exact predictions; every intermediate fits easily.
    typedef logic signed [255:0] wint;

    typedef struct {
        logic signed [31:0] p1x, p1y, v1x, v1y;
        logic [30:0]        r1;
        logic signed [31:0] p2x, p2y, v2x, v2y;
        logic [30:0]        r2;
    } pair_t;

    typedef struct {
        logic               hit;
        outcome_t           outcome;
        logic [30:0]        ctime;
        logic signed [31:0] cx, cy;
    } contact_t;

    localparam logic [30:0] ONE = 31'd65536;
    localparam logic [30:0] TICK_MAX = 31'h7FFFFFFF;
    localparam int SETTLE_CYCLES = 80;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [30:0]   cfg_wr_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [319:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;
    logic [3:0]    m_tuser;

    logic [30:0]   tick_len;
    bit            no_idle;
    contact_t      pending[$];
    int            fail_count;
    int            pair_count;
    int            hit_count;
    int            outcome_seen[5];

    swept_circle_collision_check DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Quadratic f scaled by 2^32, evaluated at time k / 2^16.
    function automatic wint scaled_f(input wint a, input wint hs, input wint cs,
                                     input logic [30:0] k);
        wint kw;
        kw = {1'b0, k};
        return a * kw * kw + 2 * hs * kw + cs;
    endfunction

    // Second circle coordinate at time k: floor, then clamp to 32-bit signed range.
    function automatic logic signed [31:0] pos_at(input logic signed [31:0] pos,
                                                  input logic signed [31:0] vel,
                                                  input logic [30:0] k);
        wint p, v, kw, hi, lo, r;
        p = pos;
        v = vel;
        kw = {1'b0, k};
        hi = 2147483647;
        lo = -hi - 1;
        r = ((p <<< 16) + v * kw) >>> 16;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[31:0];
    endfunction

    // Exact first-contact prediction for one pair under the current tick length.
    function automatic contact_t first_contact(input pair_t q);
        contact_t res;
        wint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, r1, r2;
        wint dpx, dpy, dvx, dvy, a, h, c, disc, hs, cs, lin, tk, kw;
        logic [30:0] k, cand;
        res = '{hit: 1'b0, outcome: OUT_HIT, ctime: '0, cx: '0, cy: '0};
        p1x = q.p1x; p1y = q.p1y; v1x = q.v1x; v1y = q.v1y;
        p2x = q.p2x; p2y = q.p2y; v2x = q.v2x; v2y = q.v2y;
        r1 = {1'b0, q.r1};
        r2 = {1'b0, q.r2};
        tk = {1'b0, tick_len};
        dvx = v1x - v2x; dvy = v1y - v2y;
        dpx = p1x - p2x; dpy = p1y - p2y;
        if (dvx == 0 && dvy == 0) begin
            res.outcome = OUT_STILL;
            return res;
        end
        a = dvx * dvx + dvy * dvy;
        h = dpx * dvx + dpy * dvy;
        c = dpx * dpx + dpy * dpy - (r1 + r2) * (r1 + r2);
        disc = h * h - a * c;
        if (disc < 0) begin
            res.outcome = OUT_NEVER;
            return res;
        end
        // Separating, or already overlapping at time zero: contact lies in the past.
        if (!(h <= 0 && c >= 0)) begin
            res.outcome = OUT_PAST;
            return res;
        end
        hs = h <<< 16;
        cs = c <<< 32;
        lin = a * tk + hs;
        if (lin < 0 && scaled_f(a, hs, cs, tick_len) > 0) begin
            res.outcome = OUT_BEYOND;
            return res;
        end
        // Fix one time bit per step: keep a candidate while it is not past the root.
        k = '0;
        for (int b = 30; b >= 0; b--) begin
            cand = k | (31'd1 << b);
            kw = {1'b0, cand};
            if (cand <= tick_len && a * kw + hs <= 0 && scaled_f(a, hs, cs, cand) >= 0)
                k = cand;
        end
        res.hit = 1'b1;
        res.ctime = k;
        res.cx = pos_at(q.p2x, q.v2x, k);
        res.cy = pos_at(q.p2y, q.v2y, k);
        return res;
    endfunction

    // Sends one pair, with random idle cycles unless the no-idle stretch is on.
    task automatic send_pair(input pair_t q);
        while (!no_idle && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, q.r2, q.v2y, q.v2x, q.p2y, q.p2x,
                    q.r1, q.v1y, q.v1x, q.p1y, q.p1x};
        do @(posedge aclk); while (!s_tready);
        pending.push_back(first_contact(q));
        pair_count++;
        @(negedge aclk);
    endtask

    // Drops valid, waits for all results, then lets the pipeline settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_tick(input logic [30:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tick_len = value;
    endtask

    function automatic pair_t make_pair(
        input int p1x, input int p1y, input int v1x, input int v1y, input int r1,
        input int p2x, input int p2y, input int v2x, input int v2y, input int r2);
        pair_t q;
        q.p1x = p1x; q.p1y = p1y; q.v1x = v1x; q.v1y = v1y; q.r1 = 31'(r1);
        q.p2x = p2x; q.p2y = p2y; q.v2x = v2x; q.v2y = v2y; q.r2 = 31'(r2);
        return q;
    endfunction

    // Mostly pairs on a closing course with random content, some full-range noise.
    function automatic pair_t random_pair;
        pair_t q;
        logic signed [31:0] ox, oy;
        int sh;
        if ($urandom_range(0, 99) < 20) begin
            q.p1x = $urandom; q.p1y = $urandom; q.v1x = $urandom; q.v1y = $urandom;
            q.p2x = $urandom; q.p2y = $urandom; q.v2x = $urandom; q.v2y = $urandom;
            q.r1 = 31'($urandom); q.r2 = 31'($urandom);
            return q;
        end
        sh = $urandom_range(4, 14);
        q.p2x = $signed($urandom) >>> sh;
        q.p2y = $signed($urandom) >>> sh;
        q.v2x = $signed($urandom) >>> $urandom_range(6, 16);
        q.v2y = $signed($urandom) >>> $urandom_range(6, 16);
        ox = $signed($urandom) >>> $urandom_range(6, 12);
        oy = $signed($urandom) >>> $urandom_range(6, 12);
        q.p1x = q.p2x + ox;
        q.p1y = q.p2y + oy;
        // Head roughly back along the offset, with a random speed factor and jitter.
        q.v1x = q.v2x - (ox >>> $urandom_range(0, 3)) + ($signed($urandom) >>> 22);
        q.v1y = q.v2y - (oy >>> $urandom_range(0, 3)) + ($signed($urandom) >>> 22);
        q.r1 = 31'($urandom_range(0, 1 << 22));
        q.r2 = 31'($urandom_range(0, 1 << 22));
        return q;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) send_pair(random_pair());
    endtask

    // Hand-picked pairs: each outcome, contact at both interval ends, extremes.
    task automatic test_directed;
        set_tick(ONE);
        // Same velocities: no relative motion.
        send_pair(make_pair(0, 0, 65536, 0, 65536, 10 << 16, 0, 65536, 0, 65536));
        // Passing well wide of each other.
        send_pair(make_pair(0, 0, 65536, 0, 65536, 0, 20 << 16, 0, 0, 65536));
        // Already overlapping at time zero.
        send_pair(make_pair(0, 0, 65536, 0, 65536, 65536, 0, 0, 0, 65536));
        // Moving apart.
        send_pair(make_pair(0, 0, -65536, 0, 65536, 5 << 16, 0, 0, 0, 65536));
        // Contact after the interval.
        send_pair(make_pair(0, 0, 65536, 0, 65536, 10 << 16, 0, 0, 0, 65536));
        // Contact exactly at the end of the interval.
        send_pair(make_pair(0, 0, 65536, 0, 65536, 3 << 16, 0, 0, 0, 65536));
        // Touching at time zero while closing.
        send_pair(make_pair(0, 0, 65536, 0, 65536, 2 << 16, 0, 0, 0, 65536));
        // Diagonal course, contact after the interval.
        send_pair(make_pair(0, 0, 3 << 16, 4 << 16, 32768, 9 << 16, 12 << 16, 0, 0, 32768));
        // Zero radii, exact head-on meeting.
        send_pair(make_pair(0, 0, 65536, 0, 0, 65536, 0, 0, 0, 0));
        // Second circle overtakes near the top of the range: position saturates.
        send_pair(make_pair(32'sh7FFF0000, 0, 32'sh40000000, 0, 65536,
                            32'sh7FFF0000 - (10 << 16), 0, 32'sh7FFFFFFF, 0, 65536));
        // Mirror image near the bottom of the range.
        send_pair(make_pair(32'sh80010000, 0, -32'sh40000000, 0, 65536,
                            32'sh80010000 + (10 << 16), 0, 32'sh80000000, 0, 65536));
        // Extreme field values.
        send_pair(make_pair(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                            31'h7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                            32'sh80000000, 31'h7FFFFFFF));
        send_pair(make_pair(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0,
                            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 0));
        send_pair(make_pair(-1, -1, -1, -1, 31'h7FFFFFFF, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // All zero but one velocity: moving, touching at zero separation.
        send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // Default interval; a stretch in the middle runs at full rate.
    task automatic test_default_interval;
        set_tick(ONE);
        run_random(120);
        no_idle = 1'b1;
        run_random(120);
        no_idle = 1'b0;
        run_random(60);
    endtask

    // Zero-length interval: only contact at time zero may hit.
    task automatic test_zero_interval;
        set_tick('0);
        run_random(90);
        send_pair(make_pair(0, 0, 65536, 0, 65536, 2 << 16, 0, 0, 0, 65536));
    endtask

    task automatic test_max_interval;
        set_tick(TICK_MAX);
        run_random(160);
    endtask

    // A few random settings of the interval.
    task automatic test_random_interval;
        for (int i = 0; i < 4; i++) begin
            set_tick(31'($urandom_range(1, 1 << 20)));
            run_random(70);
        end
    endtask

    // Random back-pressure on the result stream, off during the full-rate stretch.
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(0, 99) >= 35);
    end

    // Compares every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        contact_t want;
        logic [2:0] got_outcome;
        if (aresetn && m_tvalid && m_tready) begin
            got_outcome = m_tuser[3:1];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result tuser=%h tdata=%h", $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = pending.pop_front();
                outcome_seen[want.outcome]++;
                if (want.hit) hit_count++;
                if (m_tuser[0] !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_tuser[0]);
                    fail_count++;
                end
                if (got_outcome !== want.outcome) begin
                    $display("%0t: outcome expected %0d actual %0d",
                             $time, want.outcome, got_outcome);
                    fail_count++;
                end
                if (m_tdata[30:0] !== want.ctime) begin
                    $display("%0t: contact_time expected %h actual %h",
                             $time, want.ctime, m_tdata[30:0]);
                    fail_count++;
                end
                if (m_tdata[62:31] !== want.cx) begin
                    $display("%0t: contact_x expected %h actual %h",
                             $time, want.cx, m_tdata[62:31]);
                    fail_count++;
                end
                if (m_tdata[94:63] !== want.cy) begin
                    $display("%0t: contact_y expected %h actual %h",
                             $time, want.cy, m_tdata[94:63]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("timeout with %0d results outstanding", pending.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        no_idle = 1'b0;
        tick_len = ONE;
        fail_count = 0;
        pair_count = 0;
        hit_count = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_default_interval();
        test_zero_interval();
        test_max_interval();
        test_random_interval();
        drain();
        $display("%0d pairs checked, %0d hits; never %0d, past %0d, beyond %0d, still %0d",
                 pair_count, hit_count, outcome_seen[OUT_NEVER], outcome_seen[OUT_PAST],
                 outcome_seen[OUT_BEYOND], outcome_seen[OUT_STILL]);
        $display("intervals covered: zero, one, maximum and random settings");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
